// File: design/naa_pkg.sv
// Shared types, constants and elaboration-time functions for the affine activation block.
package naa_pkg;

	localparam int CURVE_TABLE_ENTRIES_DEF = 256;
	localparam int FRACTION_BITS_DEF = 12;

	typedef enum logic [2:0] {
		ACT_IDENTITY = 3'd0,
		ACT_SIGMOID  = 3'd1,
		ACT_TANH     = 3'd2,
		ACT_RELU     = 3'd3,
		ACT_LEAKY    = 3'd4
	} act_mode_t;

	// Affine result handed from the multiply stages to the curve stages.
	typedef struct packed {
		logic signed [15:0] z;
		logic               neg;
		logic [15:0]        mag;
	} naa_z_t;

	// Unsigned long division by shift and subtract, used only while filling the constant table.
	function automatic logic [63:0] div_u64(input logic [63:0] n, input logic [63:0] d);
		logic [63:0] q;
		logic [64:0] r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[63:0], n[b]};
			if (r >= {1'b0, d}) begin
				r = r - {1'b0, d};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// Sample k of tanh over the magnitude range, built in Q31 integer arithmetic.
	// Only evaluated at elaboration to fill the constant curve table.
	function automatic logic [63:0] curve_sample(input int k, input int entries, input int fb);
		logic [63:0] q31_one;
		logic [63:0] u;
		logic [63:0] w;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] e;
		logic [63:0] num;
		logic [63:0] den;
		q31_one = 64'd1 << 31;
		u = div_u64((64'(k) * 64'd32768) << (31 - fb), 64'(entries));
		w = (u << 1) >> 9;
		term = q31_one;
		sum = q31_one;
		for (int i = 1; i <= 12; i++) begin
			term = div_u64((term * w) >> 31, 64'(i));
			if ((i & 1) != 0) begin
				sum = (sum >= term) ? sum - term : 64'd0;
			end else begin
				sum = sum + term;
			end
		end
		e = sum;
		for (int j = 0; j < 9; j++) begin
			e = (e * e + (64'd1 << 30)) >> 31;
		end
		num = q31_one - ((e > q31_one) ? q31_one : e);
		den = q31_one + e;
		return div_u64((num << fb) + (den >> 1), den);
	endfunction

endpackage

// File: design/naa_affine.sv
// Two pipeline stages forming the saturated value weight times input plus bias.
module naa_affine #(
	parameter int FRACTION_BITS = naa_pkg::FRACTION_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] weight,
	input  logic signed [15:0] bias,
	input  logic signed [15:0] x_value,
	output logic               out_valid,
	input  logic               out_ready,
	output naa_pkg::naa_z_t    z_out
);
	import naa_pkg::*;

	localparam logic signed [32:0] HALF = 33'sd1 <<< (FRACTION_BITS - 1);

	logic               valid_s1;
	logic               valid_s2;
	logic               ready_s1;
	logic               ready_s2;
	logic signed [31:0] prod_s1;
	logic signed [15:0] bias_s1;
	naa_z_t             z_s2;
	naa_z_t             z_next;
	logic signed [32:0] rounded;
	logic signed [32:0] sum;
	logic signed [16:0] z_wide;

	assign ready_s2 = !valid_s2 || out_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;
	assign out_valid = valid_s2;
	assign z_out = z_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= in_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			prod_s1 <= 32'(weight) * 32'(x_value);
			bias_s1 <= bias;
		end
		if (ready_s2 && valid_s1) begin
			z_s2 <= z_next;
		end
	end

	always_comb begin
		rounded = (33'(prod_s1) + HALF) >>> FRACTION_BITS;
		sum = rounded + 33'(bias_s1);
		if (sum > 33'sd32767) begin
			z_next.z = 16'sh7fff;
		end else if (sum < -33'sd32768) begin
			z_next.z = 16'sh8000;
		end else begin
			z_next.z = 16'(sum);
		end
		z_next.neg = z_next.z[15];
		z_wide = 17'(z_next.z);
		// The most negative value has magnitude 32768, which still fits unsigned.
		z_next.mag = z_next.neg ? 16'(-z_wide) : 16'(z_wide);
	end

endmodule

// File: design/naa_curve.sv
// Three pipeline stages: table position, table read with slope, and interpolation product.
module naa_curve #(
	parameter int CURVE_TABLE_ENTRIES = naa_pkg::CURVE_TABLE_ENTRIES_DEF,
	parameter int FRACTION_BITS       = naa_pkg::FRACTION_BITS_DEF,
	localparam int CV_W = FRACTION_BITS + 1,
	localparam int PR_W = CV_W + 18
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   sig,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  naa_pkg::naa_z_t        z_in,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [CV_W-1:0]        t0,
	output logic signed [PR_W-1:0] interp,
	output logic signed [15:0]     z,
	output logic                   neg,
	output logic signed [15:0]     leaky
);
	import naa_pkg::*;

	localparam int N     = CURVE_TABLE_ENTRIES;
	localparam int IDX_W = $clog2(N + 1);
	localparam int POS_W = 16 + $clog2(N + 1);
	localparam int D_W   = CV_W + 1;
	// Leaky slope of 0.001, rounded to nearest at the fraction width.
	localparam int SLOPE = ((1 << FRACTION_BITS) + 500) / 1000;
	localparam int SL_W  = $clog2(SLOPE + 1) + 1;
	localparam int LK_W  = 17 + SL_W;
	localparam logic signed [LK_W-1:0] LK_HALF = LK_W'(1) <<< (FRACTION_BITS - 1);

	logic [CV_W-1:0] curve_tab [0:N];

	for (genvar k = 0; k <= N; k++) begin : g_tab
		localparam logic [CV_W-1:0] SAMP = CV_W'(curve_sample(k, N, FRACTION_BITS));
		assign curve_tab[k] = SAMP;
	end

	logic valid_s3, valid_s4, valid_s5;
	logic ready_s3, ready_s4, ready_s5;

	logic [IDX_W-1:0]       idx_s3;
	logic                   over_s3;
	logic [15:0]            frac_s3;
	logic signed [15:0]     z_s3;
	logic                   neg_s3;
	logic signed [LK_W-1:0] lk_prod_s3;

	logic [CV_W-1:0]        t0_s4;
	logic signed [D_W-1:0]  d_s4;
	logic [15:0]            frac_s4;
	logic signed [15:0]     z_s4;
	logic                   neg_s4;
	logic signed [15:0]     lk_s4;

	logic [CV_W-1:0]        t0_s5;
	logic signed [PR_W-1:0] interp_s5;
	logic signed [15:0]     z_s5;
	logic                   neg_s5;
	logic signed [15:0]     lk_s5;

	logic [POS_W-1:0]       pos;
	logic [POS_W-1:0]       pos_sh;
	logic [IDX_W-1:0]       idx_a;
	logic [IDX_W-1:0]       idx_b;
	logic signed [LK_W-1:0] lk_sum;

	assign ready_s5 = !valid_s5 || out_ready;
	assign ready_s4 = !valid_s4 || ready_s5;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign in_ready = ready_s3;
	assign out_valid = valid_s5;
	assign t0 = t0_s5;
	assign interp = interp_s5;
	assign z = z_s5;
	assign neg = neg_s5;
	assign leaky = lk_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (ready_s3) begin
				valid_s3 <= in_valid;
			end
			if (ready_s4) begin
				valid_s4 <= valid_s3;
			end
			if (ready_s5) begin
				valid_s5 <= valid_s4;
			end
		end
	end

	// Sigmoid looks up tanh of half the argument, so its position carries one more fraction bit.
	always_comb begin
		pos = POS_W'(z_in.mag) * POS_W'(N);
		pos_sh = sig ? (pos >> 16) : (pos >> 15);
	end

	always_comb begin
		idx_a = over_s3 ? IDX_W'(N) : idx_s3;
		idx_b = over_s3 ? IDX_W'(N) : idx_s3 + 1'b1;
		lk_sum = lk_prod_s3 + LK_HALF;
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && in_valid) begin
			idx_s3 <= IDX_W'(pos_sh);
			over_s3 <= (pos_sh >= POS_W'(N));
			frac_s3 <= sig ? pos[15:0] : {1'b0, pos[14:0]};
			z_s3 <= z_in.z;
			neg_s3 <= z_in.neg;
			lk_prod_s3 <= LK_W'(z_in.z) * LK_W'(signed'({1'b0, SL_W'(SLOPE)}));
		end
		if (ready_s4 && valid_s3) begin
			t0_s4 <= curve_tab[idx_a];
			d_s4 <= signed'({1'b0, curve_tab[idx_b]}) - signed'({1'b0, curve_tab[idx_a]});
			frac_s4 <= frac_s3;
			z_s4 <= z_s3;
			neg_s4 <= neg_s3;
			lk_s4 <= 16'(lk_sum >>> FRACTION_BITS);
		end
		if (ready_s5 && valid_s4) begin
			t0_s5 <= t0_s4;
			interp_s5 <= PR_W'(d_s4) * PR_W'(signed'({1'b0, frac_s4}));
			z_s5 <= z_s4;
			neg_s5 <= neg_s4;
			lk_s5 <= lk_s4;
		end
	end

endmodule

// File: design/neuron_affine_activation.sv
// Top level: mode register, affine and curve pipelines, and the activation output stage.
// Each of the six stages holds one item and moves on its own.
// Throughput is one item per cycle while the output is not stalled.
// A stalled output holds its result while empty stages upstream keep accepting items.
// Reset (arst_n low) clears all stage valid bits and sets the activation mode to identity.
// The curve table is constant logic, so no clearing pass follows reset.
module neuron_affine_activation #(
	parameter int CURVE_TABLE_ENTRIES = naa_pkg::CURVE_TABLE_ENTRIES_DEF,
	parameter int FRACTION_BITS       = naa_pkg::FRACTION_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [2:0]         cfg_wr_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] weight,
	input  logic signed [15:0] bias,
	input  logic signed [15:0] x_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] pre_activation,
	output logic signed [15:0] activation
);
	import naa_pkg::*;

	localparam int CV_W = FRACTION_BITS + 1;
	localparam int PR_W = CV_W + 18;
	localparam int A_W  = (FRACTION_BITS + 4 > 17) ? FRACTION_BITS + 4 : 17;
	localparam logic signed [PR_W-1:0] HALF15 = PR_W'(1) <<< 14;
	localparam logic signed [PR_W-1:0] HALF16 = PR_W'(1) <<< 15;
	localparam logic signed [A_W-1:0]  ONE    = A_W'(1) <<< FRACTION_BITS;

	logic [2:0]             mode_q;
	logic                   sig;
	logic                   aff_ready;
	logic                   aff_valid;
	logic                   crv_ready;
	logic                   crv_valid;
	naa_z_t                 aff_z;
	logic [CV_W-1:0]        crv_t0;
	logic signed [PR_W-1:0] crv_interp;
	logic signed [15:0]     crv_z;
	logic                   crv_neg;
	logic signed [15:0]     crv_leaky;

	logic                   valid_s6;
	logic                   ready_s6;
	logic signed [15:0]     pre_s6;
	logic signed [15:0]     act_s6;

	logic signed [PR_W-1:0] rnd;
	logic signed [A_W-1:0]  t_mag;
	logic signed [A_W-1:0]  t_signed;
	logic signed [A_W-1:0]  act_wide;
	logic signed [15:0]     act_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ACT_IDENTITY;
		end else if (cfg_wr_en) begin
			mode_q <= cfg_wr_data;
		end
	end

	assign sig = (mode_q == ACT_SIGMOID);

	naa_affine #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_affine (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (aff_ready),
		.weight   (weight),
		.bias     (bias),
		.x_value  (x_value),
		.out_valid(aff_valid),
		.out_ready(crv_ready),
		.z_out    (aff_z)
	);

	naa_curve #(
		.CURVE_TABLE_ENTRIES(CURVE_TABLE_ENTRIES),
		.FRACTION_BITS      (FRACTION_BITS)
	) u_curve (
		.clk      (clk),
		.arst_n   (arst_n),
		.sig      (sig),
		.in_valid (aff_valid),
		.in_ready (crv_ready),
		.z_in     (aff_z),
		.out_valid(crv_valid),
		.out_ready(ready_s6),
		.t0       (crv_t0),
		.interp   (crv_interp),
		.z        (crv_z),
		.neg      (crv_neg),
		.leaky    (crv_leaky)
	);

	assign in_stall = !aff_ready;
	assign ready_s6 = !valid_s6 || !out_stall;

	always_comb begin
		rnd = sig ? ((crv_interp + HALF16) >>> 16) : ((crv_interp + HALF15) >>> 15);
		t_mag = A_W'(signed'({1'b0, crv_t0})) + A_W'(rnd);
		t_signed = crv_neg ? -t_mag : t_mag;
		unique case (mode_q)
			ACT_SIGMOID: act_wide = (ONE + t_signed + A_W'(1)) >>> 1;
			ACT_TANH:    act_wide = t_signed;
			ACT_RELU:    act_wide = crv_neg ? '0 : A_W'(crv_z);
			ACT_LEAKY:   act_wide = crv_neg ? A_W'(crv_leaky) : A_W'(crv_z);
			default:     act_wide = A_W'(crv_z);
		endcase
		if (act_wide > A_W'(32767)) begin
			act_next = 16'sh7fff;
		end else if (act_wide < -A_W'(32768)) begin
			act_next = 16'sh8000;
		end else begin
			act_next = 16'(act_wide);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else if (ready_s6) begin
			valid_s6 <= crv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s6 && crv_valid) begin
			pre_s6 <= crv_z;
			act_s6 <= act_next;
		end
	end

	assign out_valid = valid_s6;
	assign pre_activation = pre_s6;
	assign activation = act_s6;

endmodule

// File: design/naa_checker.sv
// Port-level checker for the affine activation block, bound to the top level.
module naa_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               cfg_wr_en,
	input logic [2:0]         cfg_wr_data,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [15:0] pre_activation,
	input logic signed [15:0] activation
);
	import naa_pkg::*;

	logic [2:0] mode_q;
	logic [3:0] inflight_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ACT_IDENTITY;
			inflight_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				mode_q <= cfg_wr_data;
			end
			inflight_q <= inflight_q + 4'(in_acc) - 4'(out_acc);
		end
	end

	// A held result keeps its values until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pre_activation) && $stable(activation))
		else $error("result changed while stalled");

	// Back-pressure on the input can only come from a stalled result at the output.
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a stalled output");

	// No result appears unless an item is still in flight.
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> inflight_q != 4'd0)
		else $error("result without an accepted item");

	a_identity: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (mode_q == ACT_IDENTITY) |-> activation == pre_activation)
		else $error("identity activation differs from its input");

	a_relu: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (mode_q == ACT_RELU) |->
			activation == (pre_activation[15] ? 16'sd0 : pre_activation))
		else $error("relu activation mismatch");

endmodule

bind neuron_affine_activation naa_checker u_naa_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cfg_wr_en     (cfg_wr_en),
	.cfg_wr_data   (cfg_wr_data),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.pre_activation(pre_activation),
	.activation    (activation)
);
